// File: rtl/core/transposition_table_engine_core_defines.svh
// Assertion macros for the transposition table RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef TRANSPOSITION_TABLE_ENGINE_CORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define TTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transposition table assertion failed");

// Next-cycle implication, checked out of reset.
`define TTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transposition table assertion failed");

`else

`define TTE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TTE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Fixed field widths of the transaction payload.
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 13;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE = 2'd0,
        FUNC_PROBE = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [BOUND_W-1:0] {
        BOUND_NONE  = 2'd0,
        BOUND_EXACT = 2'd1,
        BOUND_UPPER = 2'd2,
        BOUND_LOWER = 2'd3
    } bound_t;

endpackage

`default_nettype wire

// File: rtl/core/tte_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative remainder of a 64-bit key by a 13-bit nonzero divisor.
// Four key bits are folded in per cycle, most significant first.
module tte_mod_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tte_pkg::KEY_W-1:0]  dividend,
    input  wire logic [tte_pkg::CFG_W-1:0]  divisor,
    output logic                            done,
    output logic [tte_pkg::CFG_W-1:0]       rem
);

    localparam int DIGIT_BITS = 4;
    localparam int STEPS      = tte_pkg::KEY_W / DIGIT_BITS;
    localparam int CNT_W      = $clog2(STEPS);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [tte_pkg::KEY_W-1:0]     shift_reg;
    logic [tte_pkg::CFG_W-1:0]     div_reg;
    logic [tte_pkg::CFG_W-1:0]     rem_reg;
    logic [tte_pkg::CFG_W-1:0]     rem_next;

    // Each step doubles the partial remainder, adds one key bit and reduces
    // once; the partial remainder stays below the divisor, so one subtract
    // is enough.
    always_comb
    begin
        logic [tte_pkg::CFG_W-1:0] r;
        logic [tte_pkg::CFG_W:0]   t;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            t = {r, shift_reg[tte_pkg::KEY_W-1-i]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[tte_pkg::CFG_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << DIGIT_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/transposition_table_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "transposition_table_engine_core_defines.svh"

// Direct-mapped transposition table with depth-preferred replacement. Each
// input transaction is a store, a probe or a clear, and each one returns
// exactly one result transaction (all zero except for a probe). The slot is
// the key modulo entries_in_use, clamped to TABLE_ENTRIES; with zero entries
// in use, stores and probes leave the table alone and return zeros. The
// table sits in a single-port-write, single-port-read synchronous memory
// with a registered read; one transaction is in work at a time, so
// the read, the decision and the write-back of a store never overlap with
// another access. A store or probe runs through the remainder unit (four
// key bits per cycle), the memory read, the decision that writes back or
// loads the result (held while the output register is full), and idle
// before the next acceptance. A clear, an unused func value or a disabled
// table skip the remainder unit and the read; a clear first runs a sweep
// that writes one zero entry per cycle before its result is loaded. After
// reset the same sweep runs once before in_ready first rises; the
// configuration register can be written during that time. A finished result
// waits in the output register, and the next transaction is accepted while
// it waits.
module transposition_table_engine_core #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MOVE_BITS     = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_we,
    input  wire logic [tte_pkg::CFG_W-1:0]          cfg_wdata,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tte_pkg::FUNC_W-1:0]         func,
    input  wire logic [tte_pkg::KEY_W-1:0]          key,
    input  wire logic signed [tte_pkg::DEPTH_W-1:0] depth,
    input  wire logic signed [tte_pkg::SCORE_W-1:0] score,
    input  wire logic [tte_pkg::BOUND_W-1:0]        bound_kind,
    input  wire logic [tte_pkg::MOVE_W-1:0]         move,
    input  wire logic signed [tte_pkg::SCORE_W-1:0] alpha,
    input  wire logic signed [tte_pkg::SCORE_W-1:0] beta,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    cutoff,
    output logic signed [tte_pkg::SCORE_W-1:0]      score_out,
    output logic                                    move_valid,
    output logic [tte_pkg::MOVE_W-1:0]              move_out
);

    // Moves wider than the input port cannot be stored, so the stored width
    // is the smaller of the two.
    localparam int MOVE_STORE_W = (MOVE_BITS < tte_pkg::MOVE_W) ? MOVE_BITS : tte_pkg::MOVE_W;
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [tte_pkg::KEY_W-1:0]          key;
        logic signed [tte_pkg::DEPTH_W-1:0] depth;
        logic signed [tte_pkg::SCORE_W-1:0] score;
        logic [tte_pkg::BOUND_W-1:0]        bound;
        logic [MOVE_STORE_W-1:0]            move;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic [tte_pkg::CFG_W-1:0] entries_in_use_reg;
    logic [tte_pkg::CFG_W-1:0] n_eff;
    logic                      n_nonzero;

    // Operation flags of the transaction in work.
    logic op_store_reg;
    logic op_probe_reg;
    logic clr_op_reg;

    // Latched request payload.
    logic [tte_pkg::KEY_W-1:0]          key_reg;
    logic signed [tte_pkg::DEPTH_W-1:0] depth_reg;
    logic signed [tte_pkg::SCORE_W-1:0] score_reg;
    logic [tte_pkg::BOUND_W-1:0]        bound_reg;
    logic [tte_pkg::MOVE_W-1:0]         move_reg;
    logic signed [tte_pkg::SCORE_W-1:0] alpha_reg;
    logic signed [tte_pkg::SCORE_W-1:0] beta_reg;

    // Table memory and its ports.
    entry_t           entry_mem [TABLE_ENTRIES];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           new_entry;

    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] idx_reg;

    // Remainder unit.
    logic                      mod_start;
    logic                      mod_done;
    logic [tte_pkg::CFG_W-1:0] mod_rem;
    logic [IDX_W-1:0]          mod_idx;

    // Result path.
    logic                               keep_entry;
    logic                               load_out;
    logic                               res_cutoff;
    logic signed [tte_pkg::SCORE_W-1:0] res_score;
    logic                               res_move_valid;
    logic [tte_pkg::MOVE_W-1:0]         res_move;
    logic                               out_valid_reg;
    logic                               cutoff_reg;
    logic signed [tte_pkg::SCORE_W-1:0] score_out_reg;
    logic                               move_valid_reg;
    logic [tte_pkg::MOVE_W-1:0]         move_out_reg;

    logic accept;

    // Counts above the table size fall back to the whole table.
    assign n_eff = (32'(entries_in_use_reg) > 32'(TABLE_ENTRIES)) ?
                   tte_pkg::CFG_W'(TABLE_ENTRIES) : entries_in_use_reg;
    assign n_nonzero = (n_eff != '0);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    tte_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (key),
        .divisor  (n_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // The remainder is below the clamped count, so it fits the index width.
    assign mod_idx = IDX_W'(32'(mod_rem));

    // A store leaves the slot alone when it already holds this key searched
    // deeper than the new entry.
    assign keep_entry = (rd_data_reg.key == key_reg) && (rd_data_reg.depth > depth_reg);

    assign new_entry = '{key:   key_reg,
                         depth: depth_reg,
                         score: score_reg,
                         bound: bound_reg,
                         move:  move_reg[MOVE_STORE_W-1:0]};

    // Probe evaluation on the entry just read.
    always_comb
    begin
        res_cutoff     = 1'b0;
        res_score      = '0;
        res_move_valid = 1'b0;
        res_move       = '0;
        if (op_probe_reg && (rd_data_reg.key == key_reg))
        begin
            res_move_valid = 1'b1;
            res_move       = tte_pkg::MOVE_W'(rd_data_reg.move);
            if (rd_data_reg.depth >= depth_reg)
            begin
                case (rd_data_reg.bound)
                    tte_pkg::BOUND_EXACT:
                    begin
                        res_cutoff = 1'b1;
                        res_score  = rd_data_reg.score;
                    end
                    tte_pkg::BOUND_UPPER:
                    begin
                        if (rd_data_reg.score <= alpha_reg)
                        begin
                            res_cutoff = 1'b1;
                            res_score  = alpha_reg;
                        end
                    end
                    tte_pkg::BOUND_LOWER:
                    begin
                        if (rd_data_reg.score >= beta_reg)
                        begin
                            res_cutoff = 1'b1;
                            res_score  = beta_reg;
                        end
                    end
                    default:
                    begin
                        res_cutoff = 1'b0;
                    end
                endcase
            end
        end
    end

    // Sequencer. The clear sweep writes one zero entry per cycle. A store
    // writes back only on the cycle that also loads its result, so a stalled
    // output never causes a second write.
    always_comb
    begin
        state_next = state_reg;
        mod_start  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = clr_idx_reg;
        mem_wdata  = '0;
        mem_raddr  = mod_idx;
        load_out   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = clr_op_reg ? S_EXEC : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == tte_pkg::FUNC_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (((func == tte_pkg::FUNC_STORE) || (func == tte_pkg::FUNC_PROBE))
                             && n_nonzero)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    mem_re     = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (op_store_reg && !keep_entry)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = new_entry;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            entries_in_use_reg <= '0;
            op_store_reg       <= 1'b0;
            op_probe_reg       <= 1'b0;
            clr_op_reg         <= 1'b0;
            clr_idx_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                entries_in_use_reg <= cfg_wdata;
            end
            if (accept)
            begin
                op_store_reg <= (func == tte_pkg::FUNC_STORE) && n_nonzero;
                op_probe_reg <= (func == tte_pkg::FUNC_PROBE) && n_nonzero;
                clr_op_reg   <= (func == tte_pkg::FUNC_CLEAR);
                clr_idx_reg  <= '0;
            end
            else if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= key;
            depth_reg <= depth;
            score_reg <= score;
            bound_reg <= bound_kind;
            move_reg  <= move;
            alpha_reg <= alpha;
            beta_reg  <= beta;
        end
        if (mod_done)
        begin
            idx_reg <= mod_idx;
        end
        if (load_out)
        begin
            cutoff_reg     <= res_cutoff;
            score_out_reg  <= res_score;
            move_valid_reg <= res_move_valid;
            move_out_reg   <= res_move;
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign cutoff     = cutoff_reg;
    assign score_out  = score_out_reg;
    assign move_valid = move_valid_reg;
    assign move_out   = move_out_reg;

    // Writes come only from the clear sweep or the write-back cycle.
    `TTE_ASSERT_IMP(a_we_state, clk, rst_n, mem_we, (state_reg == S_CLEAR) || (state_reg == S_EXEC))
    // A store blocked by a full output register must not write yet.
    `TTE_ASSERT_IMP(a_no_we_stall, clk, rst_n, (state_reg == S_EXEC) && out_valid_reg && !out_ready, !mem_we)
    // The remainder unit only finishes while the sequencer waits for it.
    `TTE_ASSERT_IMP(a_mod_done_state, clk, rst_n, mod_done, state_reg == S_MOD)
    // An accepted transaction always leaves idle.
    `TTE_ASSERT_NXT(a_accept_leaves, clk, rst_n, accept, state_reg != S_IDLE)
    // Reads and writes of the table never share a cycle.
    `TTE_ASSERT_IMP(a_rw_apart, clk, rst_n, mem_re, !mem_we)

endmodule

`default_nettype wire
